FILE: sv/mrcm_pkg.sv
// ----------------------------------------------------------------------------
// mrcm_pkg
// Shared widths, command and register codes for the row chunk multiplier.
// ----------------------------------------------------------------------------
package mrcm_pkg;

  // default matrix dimension
  localparam int MAT_DIM_DEF = 16;

  // field widths
  localparam int IDX_W  = 4;
  localparam int ELEM_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W  = 48;
  localparam int ACC_W  = 56;
  localparam int CMD_W  = 2;

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CNT_W      = 5;

  // item commands
  localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_C    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd1;

  // multiply-accumulate controls
  typedef struct packed {
    logic load;
    logic add;
  } mac_ctl_t;

endpackage

FILE: sv/mrcm_ram.sv
// ----------------------------------------------------------------------------
// mrcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mrcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mrcm_mac.sv
// ----------------------------------------------------------------------------
// mrcm_mac
// Registered multiplier, wide accumulator and 48-bit saturation of the sum.
// ----------------------------------------------------------------------------
module mrcm_mac (
  input  logic                                clk,
  input  mrcm_pkg::mac_ctl_t                  ctl,
  input  logic signed [mrcm_pkg::ELEM_W-1:0]  a_data,
  input  logic signed [mrcm_pkg::ELEM_W-1:0]  b_data,
  input  logic signed [mrcm_pkg::SUM_W-1:0]   c_data,
  output logic signed [mrcm_pkg::SUM_W-1:0]   sum_sat,
  output logic                                sat
);

  localparam int ACC_W  = mrcm_pkg::ACC_W;
  localparam int SUM_W  = mrcm_pkg::SUM_W;
  localparam int PROD_W = mrcm_pkg::PROD_W;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-SUM_W:0]     top_bits;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= a_data * b_data;
  end

  // accumulator: load stored element, then add products
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = {{(ACC_W-SUM_W){c_data[SUM_W-1]}}, c_data};
    end else if (ctl.add) begin
      acc_nxt = acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // clip to the 48-bit range
  assign top_bits = acc_r[ACC_W-1:SUM_W-1];
  assign sat = !((top_bits == '0) || (top_bits == '1));

  always_comb begin
    if (!sat) begin
      sum_sat = acc_r[SUM_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

endmodule

FILE: sv/matrix_row_chunk_multiply.sv
// A compute item passes through the run, drain and write-back states; the result is registered after write-back.
// A new item is accepted only while idle, so compute items do not overlap; one read of A and B per term.
// Write items (A, B or C element) are written as they are accepted and busy stays low for them.
// The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset: first_row 0, row_count 16, matrices undefined until written.
// ----------------------------------------------------------------------------
// matrix_row_chunk_multiply
// Dense matrix multiply-accumulate, one C element per compute item, for rows
// inside a configured chunk; A, B and C kept in synchronous RAMs.
// ----------------------------------------------------------------------------
module matrix_row_chunk_multiply #(
  parameter int MAT_DIM = mrcm_pkg::MAT_DIM_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // item channel
  input  logic                                  start,
  output logic                                  busy,
  input  logic [mrcm_pkg::CMD_W-1:0]            in_cmd,
  input  logic [mrcm_pkg::IDX_W-1:0]            in_row_index,
  input  logic [mrcm_pkg::IDX_W-1:0]            in_col_index,
  input  logic signed [mrcm_pkg::ELEM_W-1:0]    in_element,
  input  logic signed [mrcm_pkg::SUM_W-1:0]     in_initial_sum,
  // result channel
  output logic                                  out_valid,
  output logic signed [mrcm_pkg::SUM_W-1:0]     out_sum_value,
  output logic                                  out_row_in_chunk,
  output logic                                  out_saturated,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mrcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mrcm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = MAT_DIM * MAT_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
  localparam int IDX_W = mrcm_pkg::IDX_W;
  localparam int SUM_W = mrcm_pkg::SUM_W;
  localparam int CNT_W = mrcm_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_WB    = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             k_last;

  logic [IDX_W-1:0] first_row_r;
  logic [CNT_W-1:0] row_count_r;

  logic [IDX_W-1:0] row_r, col_r;
  logic [AW-1:0]    pos_r;
  logic             valid_r, chunk_r;

  logic rd_v_r, rd_first_r, rd_last_r, prod_v_r, prod_last_r;

  logic             out_valid_r, out_chunk_r, out_sat_r;
  logic [SUM_W-1:0] out_sum_r;

  logic             accept, accept_cmp, idx_valid, in_chunk;
  logic [AW-1:0]    in_pos;
  logic [CNT_W:0]   chunk_end;

  logic [AW-1:0]    a_raddr, b_raddr;
  logic             a_we, b_we, c_we;
  logic [AW-1:0]    c_waddr;
  logic [SUM_W-1:0] c_wdata;
  logic signed [mrcm_pkg::ELEM_W-1:0] a_rdata, b_rdata;
  logic signed [SUM_W-1:0]            c_rdata, sum_sat;
  logic                               sat;
  mrcm_pkg::mac_ctl_t                 mac_ctl;

  // item decode
  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign accept_cmp = accept && (in_cmd == mrcm_pkg::CMD_COMPUTE);
  assign idx_valid  = (int'(in_row_index) < MAT_DIM) && (int'(in_col_index) < MAT_DIM);
  assign in_pos     = AW'(int'(in_row_index) * MAT_DIM + int'(in_col_index));
  assign chunk_end  = {1'b0, row_count_r} + {2'b00, first_row_r};
  assign in_chunk   = (in_row_index >= first_row_r) &&
                      ({2'b00, in_row_index} < chunk_end);

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= '0;
      row_count_r <= CNT_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mrcm_pkg::REG_FIRST_ROW: first_row_r <= cfg_data[IDX_W-1:0];
        mrcm_pkg::REG_ROW_COUNT: row_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign k_last = (int'(k_r) == MAT_DIM - 1);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (accept_cmp) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + KW'(1);
        if (k_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (prod_last_r) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      rd_first_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rd_v_r      <= (state_r == ST_RUN);
      rd_first_r  <= (state_r == ST_RUN) && (k_r == '0);
      rd_last_r   <= (state_r == ST_RUN) && k_last;
      prod_v_r    <= rd_v_r;
      prod_last_r <= rd_last_r;
    end
  end

  // compute item fields, out-of-range indexes fold to entry zero
  always_ff @(posedge clk) begin
    if (accept_cmp) begin
      valid_r <= idx_valid;
      chunk_r <= idx_valid && in_chunk;
      row_r   <= idx_valid ? in_row_index : '0;
      col_r   <= idx_valid ? in_col_index : '0;
      pos_r   <= idx_valid ? in_pos : '0;
    end
  end

  // read addresses for the current term
  assign a_raddr = AW'(int'(row_r) * MAT_DIM + int'(k_r));
  assign b_raddr = AW'(int'(k_r) * MAT_DIM + int'(col_r));

  // write enables: element loads from the item port, sum write-back from the sequencer
  assign a_we    = accept && idx_valid && (in_cmd == mrcm_pkg::CMD_WR_A);
  assign b_we    = accept && idx_valid && (in_cmd == mrcm_pkg::CMD_WR_B);
  assign c_we    = (accept && idx_valid && (in_cmd == mrcm_pkg::CMD_WR_C)) ||
                   ((state_r == ST_WB) && chunk_r);
  assign c_waddr = (state_r == ST_WB) ? pos_r : in_pos;
  assign c_wdata = (state_r == ST_WB) ? sum_sat : in_initial_sum;

  mrcm_ram #(.WIDTH(mrcm_pkg::ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (in_pos),
    .wdata (in_element),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mrcm_ram #(.WIDTH(mrcm_pkg::ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_pos),
    .wdata (in_element),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mrcm_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_ram_c (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (pos_r),
    .rdata (c_rdata)
  );

  // accumulator controls
  assign mac_ctl.load = rd_first_r;
  assign mac_ctl.add  = prod_v_r && chunk_r;

  mrcm_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .a_data  (a_rdata),
    .b_data  (b_rdata),
    .c_data  (c_rdata),
    .sum_sat (sum_sat),
    .sat     (sat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WB) begin
      out_sum_r   <= valid_r ? sum_sat : '0;
      out_chunk_r <= chunk_r;
      out_sat_r   <= chunk_r && sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sum_value    = out_sum_r;
  assign out_row_in_chunk = out_chunk_r;
  assign out_saturated    = out_sat_r;

`ifndef SYNTHESIS
  a_cmp_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept_cmp |=> busy)
    else $error("compute item did not start the sequencer");

  a_result_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_WB))
    else $error("result strobe without write-back cycle");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_sat_in_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_row_in_chunk)
    else $error("saturation flagged outside the chunk");
`endif

endmodule

FILE: dv/tb_matrix_row_chunk_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_row_chunk_multiply
// Self-checking bench for the row chunk multiplier. All of A and B is loaded
// first and every C element is written before its first compute, then
// directed items hit both saturation limits, then random write and compute
// items run under several row chunk settings. A predictor tracks the
// matrices and the chunk and checks every result in order.
// ----------------------------------------------------------------------------
module tb_matrix_row_chunk_multiply;
  import mrcm_pkg::*;

  localparam int     DIM        = MAT_DIM_DEF;
  localparam int     SETTLE_CYC = DIM + 8;
  localparam longint RUN_LIMIT  = 10_000_000;
  localparam longint ACC_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_BOT    = -ACC_TOP - 1;
  localparam logic signed [SUM_W-1:0]  SUM_TOP  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0]  SUM_BOT  = 48'sh8000_0000_0000;
  localparam logic signed [ELEM_W-1:0] ELEM_TOP = 16'sh7FFF;
  localparam logic signed [ELEM_W-1:0] ELEM_BOT = 16'sh8000;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [IDX_W-1:0]          row;
    logic [IDX_W-1:0]          col;
    logic signed [ELEM_W-1:0]  element;
    logic signed [SUM_W-1:0]   init_sum;
  } mat_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    in_chunk;
    logic                    sat;
  } sum_result_t;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0]         in_cmd = CMD_WR_A;
  logic [IDX_W-1:0]         in_row_index = '0;
  logic [IDX_W-1:0]         in_col_index = '0;
  logic signed [ELEM_W-1:0] in_element = '0;
  logic signed [SUM_W-1:0]  in_initial_sum = '0;
  logic                     out_valid;
  logic signed [SUM_W-1:0]  out_sum_value;
  logic                     out_row_in_chunk;
  logic                     out_saturated;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = REG_FIRST_ROW;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // predictor state
  logic signed [ELEM_W-1:0] a_mem [DIM*DIM];
  logic signed [ELEM_W-1:0] b_mem [DIM*DIM];
  logic signed [SUM_W-1:0]  c_mem [DIM*DIM];
  bit                       c_written [DIM*DIM];
  int chunk_first = 0;
  int chunk_count = 16;

  mat_item_t   item_pending [$];
  sum_result_t sum_expected [$];
  mat_item_t   cur_item;
  int items_queued = 0;
  int items_taken = 0;
  int fault_cnt = 0;
  int burst_left = 0;
  int gap_left = 0;

  matrix_row_chunk_multiply dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element       (in_element),
    .in_initial_sum   (in_initial_sum),
    .out_valid        (out_valid),
    .out_sum_value    (out_sum_value),
    .out_row_in_chunk (out_row_in_chunk),
    .out_saturated    (out_saturated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // apply one accepted item to the matrices, queue the sum it returns
  function automatic void mac_predict(mat_item_t it);
    int          pos;
    int          k;
    bit          in_range;
    longint      acc;
    sum_result_t res;
    in_range = (int'(it.row) < DIM) && (int'(it.col) < DIM);
    pos = int'(it.row) * DIM + int'(it.col);
    res = '0;
    case (it.cmd)
      CMD_WR_A: if (in_range) a_mem[pos] = it.element;
      CMD_WR_B: if (in_range) b_mem[pos] = it.element;
      CMD_WR_C: if (in_range) c_mem[pos] = it.init_sum;
      default: begin
        if (in_range) begin
          acc = longint'(c_mem[pos]);
          res.in_chunk = (int'(it.row) >= chunk_first) &&
                         (int'(it.row) < chunk_first + chunk_count);
          if (res.in_chunk) begin
            for (k = 0; k < DIM; k++) begin
              acc += longint'(a_mem[int'(it.row) * DIM + k]) *
                     longint'(b_mem[k * DIM + int'(it.col)]);
            end
            if (acc > ACC_TOP) begin
              acc = ACC_TOP;
              res.sat = 1'b1;
            end else if (acc < ACC_BOT) begin
              acc = ACC_BOT;
              res.sat = 1'b1;
            end
            c_mem[pos] = acc[SUM_W-1:0];
          end
          res.sum = acc[SUM_W-1:0];
        end
        sum_expected.push_back(res);
      end
    endcase
  endfunction

  function automatic void log_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%t ERROR: %s", $realtime, msg);
  endfunction

  function automatic void push_item(logic [CMD_W-1:0] cmd, int row, int col,
                                    logic signed [ELEM_W-1:0] element,
                                    logic signed [SUM_W-1:0] init_sum);
    mat_item_t it;
    int        pos;
    pos = row * DIM + col;
    it.row = row[IDX_W-1:0];
    it.col = col[IDX_W-1:0];
    it.element = element;
    it.init_sum = init_sum;
    // a compute reads its C element, so write it first if still unwritten
    if (cmd == CMD_COMPUTE && !c_written[pos]) begin
      it.cmd = CMD_WR_C;
      item_pending.push_back(it);
      items_queued++;
    end
    if (cmd == CMD_WR_C || cmd == CMD_COMPUTE) c_written[pos] = 1'b1;
    it.cmd = cmd;
    item_pending.push_back(it);
    items_queued++;
  endfunction

  function automatic logic signed [ELEM_W-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return ELEM_TOP;
      1:       return ELEM_BOT;
      2:       return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // starting sums, biased toward the clip limits
  function automatic logic signed [SUM_W-1:0] rand_sum();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return SUM_TOP;
      1:       return SUM_BOT;
      2:       return SUM_TOP - (48'(r) << 2);
      3:       return SUM_BOT + (48'(r) << 2);
      4:       return {{16{r[31]}}, r};
      5:       return '0;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // write-C-then-accumulate sequences in three of ten draws, the rest loose writes and computes
  function automatic void push_random_items(int n);
    int cnt;
    int r;
    int c;
    int reps;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, DIM - 1);
      c = $urandom_range(0, DIM - 1);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          push_item(CMD_WR_C, r, c, rand_element(), rand_sum());
          if ($urandom_range(0, 1) == 1)
            push_item(CMD_WR_A, r, $urandom_range(0, DIM - 1), rand_element(), rand_sum());
          if ($urandom_range(0, 1) == 1)
            push_item(CMD_WR_B, $urandom_range(0, DIM - 1), c, rand_element(), rand_sum());
          reps = $urandom_range(1, 3);
          repeat (reps) push_item(CMD_COMPUTE, r, c, rand_element(), rand_sum());
          cnt += reps + 1;
        end
        3: begin
          push_item(CMD_WR_A, r, c, rand_element(), rand_sum());
          cnt++;
        end
        4: begin
          push_item(CMD_WR_B, r, c, rand_element(), rand_sum());
          cnt++;
        end
        5: begin
          push_item(CMD_WR_C, r, c, rand_element(), rand_sum());
          cnt++;
        end
        default: begin
          push_item(CMD_COMPUTE, r, c, rand_element(), rand_sum());
          cnt++;
        end
      endcase
    end
  endfunction

  // wait for every item taken and every sum returned, then let the block settle
  task automatic wait_idle();
    @(posedge clk);
    while (items_taken != items_queued || sum_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FIRST_ROW) chunk_first = int'(val[IDX_W-1:0]);
    else if (idx == REG_ROW_COUNT) chunk_count = int'(val);
    @(posedge clk);
  endtask

  task automatic run_phase(int first, int count, int n);
    wait_idle();
    cfg_write(REG_FIRST_ROW, CFG_DATA_W'(first));
    cfg_write(REG_ROW_COUNT, CFG_DATA_W'(count));
    push_random_items(n);
  endtask

  // item driver: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        mac_predict(cur_item);
        items_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0 || item_pending.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          cur_item = item_pending.pop_front();
          start          <= 1'b1;
          in_cmd         <= cur_item.cmd;
          in_row_index   <= cur_item.row;
          in_col_index   <= cur_item.col;
          in_element     <= cur_item.element;
          in_initial_sum <= cur_item.init_sum;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end
        end
      end
    end
  end

  // result monitor, in-order compare
  always @(posedge clk) begin
    sum_result_t want;
    if (rst_n && out_valid) begin
      if (sum_expected.size() == 0) begin
        log_fault($sformatf("unexpected result sum=%0d in_chunk=%0b sat=%0b",
                            out_sum_value, out_row_in_chunk, out_saturated));
      end else begin
        want = sum_expected.pop_front();
        if (out_sum_value !== want.sum || out_row_in_chunk !== want.in_chunk ||
            out_saturated !== want.sat)
          log_fault($sformatf("exp sum=%0d in_chunk=%0b sat=%0b, got sum=%0d in_chunk=%0b sat=%0b",
                              want.sum, want.in_chunk, want.sat,
                              out_sum_value, out_row_in_chunk, out_saturated));
      end
    end
  end

  // stimulus
  initial begin
    int r;
    int c;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_write(REG_FIRST_ROW, 5'd0);
    cfg_write(REG_ROW_COUNT, 5'd16);

    // load every A and B entry; row 0 of A and columns 0 and 1 of B hold the extremes
    for (r = 0; r < DIM; r++) begin
      for (c = 0; c < DIM; c++) begin
        push_item(CMD_WR_A, r, c, (r == 0) ? ELEM_BOT : rand_element(), '0);
        push_item(CMD_WR_B, r, c, (c == 0) ? ELEM_BOT : (c == 1) ? ELEM_TOP : rand_element(),
                  '0);
      end
    end

    // clip high, clip low, stay clipped, edge rows and columns
    push_item(CMD_WR_C, 0, 0, '0, SUM_TOP);
    push_item(CMD_COMPUTE, 0, 0, '0, '0);
    push_item(CMD_WR_C, 0, 1, '0, SUM_BOT);
    push_item(CMD_COMPUTE, 0, 1, '0, '0);
    push_item(CMD_COMPUTE, 0, 0, '0, '0);
    push_item(CMD_WR_A, 15, 0, ELEM_TOP, '0);
    push_item(CMD_WR_B, 0, 15, ELEM_BOT, '0);
    push_item(CMD_WR_C, 15, 15, 16'shFFFF, '0);
    push_item(CMD_COMPUTE, 15, 15, '0, '0);
    push_item(CMD_WR_C, 7, 9, '0, '1);
    push_item(CMD_COMPUTE, 7, 9, ELEM_TOP, SUM_TOP);
    push_item(CMD_WR_A, 3, 3, 16'shFFFF, SUM_TOP);
    push_item(CMD_WR_C, 3, 12, ELEM_BOT, 48'sh0000_0000_0001);
    push_item(CMD_COMPUTE, 3, 12, '0, '0);
    push_item(CMD_COMPUTE, 3, 12, '0, '0);

    run_phase(0, 0, 20);
    run_phase(15, 1, 20);
    run_phase(15, 16, 20);
    run_phase(5, 7, 20);
    run_phase(0, 1, 20);
    run_phase($urandom_range(0, 15), $urandom_range(0, 16), 25);
    run_phase(0, 16, 25);
    wait_idle();

    if (fault_cnt == 0) begin
      $display("** matrix_row_chunk_multiply: PASSED **");
    end else begin
      $display("** matrix_row_chunk_multiply: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("** matrix_row_chunk_multiply: FAILED **");
    $finish;
  end

endmodule
